### sv/xaa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xaa_pkg: shared definitions for the x86 arithmetic ALU
// Operation codes, widths and the command bundle that the controller sends to
// the datapath.
// ----------------------------------------------------------------------------
package xaa_pkg;

  // Operand widths.
  localparam int WORD_BITS = 16;
  localparam int BYTE_BITS = WORD_BITS / 2;

  // Shift-add and restoring-division steps per multiply or divide instruction.
  localparam int STEP_COUNT = WORD_BITS;
  localparam int STEP_CNT_W = $clog2(STEP_COUNT);

  typedef logic [2:0] mode_t;

  // Operation codes.
  localparam mode_t MODE_ADD = 3'd0;
  localparam mode_t MODE_ADC = 3'd1;
  localparam mode_t MODE_SUB = 3'd2;
  localparam mode_t MODE_SBB = 3'd3;
  localparam mode_t MODE_MUL = 3'd4;
  localparam mode_t MODE_DIV = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the operands of an accepted beat
    logic step;    // one multiply or divide iteration
    logic finish;  // form the result and update the flags
  } xaa_cmd_t;

endpackage : xaa_pkg
`default_nettype wire

### sv/xaa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xaa_ctrl: sequencer for the x86 arithmetic ALU
// Accepts a command beat, runs the iteration count for multiply and divide,
// and raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module xaa_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire xaa_pkg::mode_t in_mode,
  output logic                busy,
  output logic                out_valid,
  output xaa_pkg::xaa_cmd_t   cmd
);
  import xaa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(STEP_COUNT - 1);

  logic [1:0]            state_r, state_nxt;
  logic [STEP_CNT_W-1:0] count_r, count_nxt;
  logic                  valid_r, valid_nxt;
  logic                  accept;
  logic                  iterative;

  assign accept    = start && (state_r == ST_IDLE);
  assign iterative = (in_mode == MODE_MUL) || (in_mode == MODE_DIV);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt = '0;
          state_nxt = iterative ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        count_nxt = count_r + 1'b1;
        if (count_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Commands and status.
  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = valid_r;
  assign cmd.load   = accept;
  assign cmd.step   = (state_r == ST_RUN);
  assign cmd.finish = (state_r == ST_DONE);

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted beat did not raise busy");

  // The finishing cycle is always followed by the result strobe.
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_valid) else $error("result strobe missing");

  // The strobe lasts a single cycle.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // Iteration ends only after the final step.
  a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && (count_r != LAST_STEP)) |=> (state_r == ST_RUN))
    else $error("iteration left early");

endmodule : xaa_ctrl
`default_nettype wire

### sv/xaa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xaa_dp: datapath of the x86 arithmetic ALU
// Operand registers, a shared shift-add multiplier and restoring divider,
// the add/subtract unit, the persistent flags and the result registers.
// ----------------------------------------------------------------------------
module xaa_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire xaa_pkg::xaa_cmd_t             cmd,
  input  wire xaa_pkg::mode_t                in_mode,
  input  wire                                in_is_word,
  input  wire [xaa_pkg::WORD_BITS-1:0]       in_first_value,
  input  wire [xaa_pkg::WORD_BITS-1:0]       in_second_value,
  output logic [xaa_pkg::WORD_BITS-1:0]      out_result_low,
  output logic [xaa_pkg::WORD_BITS-1:0]      out_result_high,
  output logic                               out_carry_out,
  output logic                               out_zero_out,
  output logic                               out_overflow_out,
  output logic                               out_divide_error
);
  import xaa_pkg::*;

  // Operand registers.
  mode_t                mode_r;
  logic                 word_r;
  logic [WORD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0] b_r;

  // Shared iteration registers: high product word or partial remainder, and
  // multiplier or dividend/quotient.
  logic [WORD_BITS-1:0] hi_r, hi_nxt;
  logic [WORD_BITS-1:0] lo_r, lo_nxt;

  // Flags.
  logic carry_r, zero_r, ovf_r;
  logic carry_nxt, zero_nxt, ovf_nxt;

  // Result registers.
  logic [WORD_BITS-1:0] res_lo_r, res_lo_nxt;
  logic [WORD_BITS-1:0] res_hi_r, res_hi_nxt;
  logic                 derr_r, derr_nxt;

  // Iteration terms.
  logic [WORD_BITS-1:0] mcand;
  logic [WORD_BITS:0]   mul_sum;
  logic [BYTE_BITS-1:0] divisor;
  logic [BYTE_BITS:0]   div_trial;
  logic                 div_ge;
  logic [BYTE_BITS:0]   div_rem;

  // Add/subtract terms.
  logic [WORD_BITS-1:0] a_m, b_m, as_res;
  logic [WORD_BITS:0]   sum_w, diff_w;
  logic                 cin, is_sub, a_sign, b_sign, r_sign, as_carry;

  // One step of multiply (shift-add) or divide (restoring).
  always_comb begin
    mcand     = word_r ? b_r : {{BYTE_BITS{1'b0}}, b_r[BYTE_BITS-1:0]};
    mul_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand} : '0);
    divisor   = b_r[BYTE_BITS-1:0];
    div_trial = {hi_r[BYTE_BITS-1:0], lo_r[WORD_BITS-1]};
    div_ge    = (div_trial >= {1'b0, divisor});
    div_rem   = div_ge ? (div_trial - {1'b0, divisor}) : div_trial;
    if (mode_r == MODE_DIV) begin
      hi_nxt = {{BYTE_BITS{1'b0}}, div_rem[BYTE_BITS-1:0]};
      lo_nxt = {lo_r[WORD_BITS-2:0], div_ge};
    end else begin
      hi_nxt = mul_sum[WORD_BITS:1];
      lo_nxt = {mul_sum[0], lo_r[WORD_BITS-1:1]};
    end
  end

  // Operand capture and iteration.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      word_r <= in_is_word;
      a_r    <= in_first_value;
      b_r    <= in_second_value;
      hi_r   <= '0;
      if ((in_mode == MODE_MUL) && !in_is_word) begin
        lo_r <= {{BYTE_BITS{1'b0}}, in_first_value[BYTE_BITS-1:0]};
      end else begin
        lo_r <= in_first_value;
      end
    end else if (cmd.step) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  // Add and subtract at the operand width.
  always_comb begin
    is_sub   = (mode_r == MODE_SUB) || (mode_r == MODE_SBB);
    cin      = ((mode_r == MODE_ADC) || (mode_r == MODE_SBB)) ? carry_r : 1'b0;
    a_m      = word_r ? a_r : {{BYTE_BITS{1'b0}}, a_r[BYTE_BITS-1:0]};
    b_m      = word_r ? b_r : {{BYTE_BITS{1'b0}}, b_r[BYTE_BITS-1:0]};
    sum_w    = {1'b0, a_m} + {1'b0, b_m} + {{WORD_BITS{1'b0}}, cin};
    diff_w   = {1'b0, a_m} - {1'b0, b_m} - {{WORD_BITS{1'b0}}, cin};
    as_res   = is_sub ? diff_w[WORD_BITS-1:0] : sum_w[WORD_BITS-1:0];
    if (!word_r) begin
      as_res = {{BYTE_BITS{1'b0}}, as_res[BYTE_BITS-1:0]};
    end
    // A borrow shows as a wrap of the extended difference at either width.
    if (is_sub) begin
      as_carry = diff_w[WORD_BITS];
    end else begin
      as_carry = word_r ? sum_w[WORD_BITS] : sum_w[BYTE_BITS];
    end
    a_sign = word_r ? a_m[WORD_BITS-1] : a_m[BYTE_BITS-1];
    b_sign = word_r ? b_m[WORD_BITS-1] : b_m[BYTE_BITS-1];
    r_sign = word_r ? as_res[WORD_BITS-1] : as_res[BYTE_BITS-1];
  end

  // Result and flag selection on the finishing cycle.
  always_comb begin
    res_lo_nxt = '0;
    res_hi_nxt = '0;
    derr_nxt   = 1'b0;
    carry_nxt  = carry_r;
    zero_nxt   = zero_r;
    ovf_nxt    = ovf_r;
    case (mode_r)
      MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBB: begin
        res_lo_nxt = as_res;
        carry_nxt  = as_carry;
        zero_nxt   = (as_res == '0);
        if (is_sub) begin
          ovf_nxt = (a_sign ^ b_sign) & (a_sign ^ r_sign);
        end else begin
          ovf_nxt = ~(a_sign ^ b_sign) & (a_sign ^ r_sign);
        end
      end
      MODE_MUL: begin
        res_lo_nxt = lo_r;
        if (word_r) begin
          res_hi_nxt = hi_r;
          carry_nxt  = (hi_r != '0);
        end else begin
          carry_nxt  = (lo_r[WORD_BITS-1:BYTE_BITS] != '0);
        end
        ovf_nxt = carry_nxt;
      end
      MODE_DIV: begin
        // Zero divisor or a quotient that does not fit in a byte.
        derr_nxt = (divisor == '0) || (lo_r[WORD_BITS-1:BYTE_BITS] != '0);
        if (derr_nxt) begin
          res_lo_nxt = a_r;
        end else begin
          res_lo_nxt = {hi_r[BYTE_BITS-1:0], lo_r[BYTE_BITS-1:0]};
        end
      end
      default: begin
        res_lo_nxt = '0;
      end
    endcase
  end

  // Persistent flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 1'b0;
      zero_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (cmd.finish) begin
      carry_r <= carry_nxt;
      zero_r  <= zero_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_lo_r <= res_lo_nxt;
      res_hi_r <= res_hi_nxt;
      derr_r   <= derr_nxt;
    end
  end

  assign out_result_low   = res_lo_r;
  assign out_result_high  = res_hi_r;
  assign out_carry_out    = carry_r;
  assign out_zero_out     = zero_r;
  assign out_overflow_out = ovf_r;
  assign out_divide_error = derr_r;

  // A divide never changes the flags.
  a_div_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (mode_r == MODE_DIV)) |=> $stable({carry_r, zero_r, ovf_r}))
    else $error("divide altered the flags");

  // Multiply leaves carry and overflow equal.
  a_mul_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (mode_r == MODE_MUL)) |=> (carry_r == ovf_r))
    else $error("multiply flags disagree");

  // A divide error only comes from a divide.
  a_derr_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (mode_r != MODE_DIV)) |=> !derr_r)
    else $error("divide error outside a divide");

endmodule : xaa_dp
`default_nettype wire

### sv/x86_arith_alu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86_arith_alu_core: x86 integer arithmetic unit
// ADD, ADC, SUB, SBB, unsigned MUL and unsigned byte DIV with persistent
// carry, zero and overflow flags.
// ----------------------------------------------------------------------------
// Sequence: ADD/ADC/SUB/SBB and unused codes go from the start beat straight
// to the finish state; MUL and DIV first make 16 passes through the shared
// shift-add / restoring-divide step. The result strobe follows the finish.
// The block takes no new beat while one is in flight; start is taken whenever
// busy is low, including the cycle the previous result is strobed.
// Reset (synchronous, rst_n low) clears the flags and the controller.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module x86_arith_alu_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire [2:0]                         in_mode,
  input  wire                               in_is_word,
  input  wire [xaa_pkg::WORD_BITS-1:0]      in_first_value,
  input  wire [xaa_pkg::WORD_BITS-1:0]      in_second_value,
  output logic                              out_valid,
  output logic [xaa_pkg::WORD_BITS-1:0]     out_result_low,
  output logic [xaa_pkg::WORD_BITS-1:0]     out_result_high,
  output logic                              out_carry_out,
  output logic                              out_zero_out,
  output logic                              out_overflow_out,
  output logic                              out_divide_error
);
  import xaa_pkg::*;

  xaa_cmd_t cmd;

  // Sequencer.
  xaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Operand, iteration, flag and result registers.
  xaa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_is_word       (in_is_word),
    .in_first_value   (in_first_value),
    .in_second_value  (in_second_value),
    .out_result_low   (out_result_low),
    .out_result_high  (out_result_high),
    .out_carry_out    (out_carry_out),
    .out_zero_out     (out_zero_out),
    .out_overflow_out (out_overflow_out),
    .out_divide_error (out_divide_error)
  );

endmodule : x86_arith_alu_core
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the x86 arithmetic ALU
// A driver feeds instruction beats from a queue in random bursts and a monitor
// predicts each accepted beat's sum, difference, product or quotient and the
// running carry, zero and overflow flags, then compares every result beat
// field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import xaa_pkg::*;

  localparam int W = WORD_BITS;
  localparam int RANDOM_OPS = 1530;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 24;

  // Codes with no operation behind them.
  localparam mode_t MODE_SPARE6 = 3'd6;
  localparam mode_t MODE_SPARE7 = 3'd7;

  typedef struct {
    mode_t        mode;
    logic         is_word;
    logic [W-1:0] first_value;
    logic [W-1:0] second_value;
    bit           wait_for_drain;
  } alu_instr_t;

  typedef struct {
    logic [W-1:0] result_low;
    logic [W-1:0] result_high;
    logic         carry;
    logic         zero;
    logic         overflow;
    logic         divide_error;
  } alu_result_t;

  logic         clk;
  logic         rst_n;
  logic         start;
  logic         busy;
  logic [2:0]   in_mode;
  logic         in_is_word;
  logic [W-1:0] in_first_value;
  logic [W-1:0] in_second_value;
  logic         out_valid;
  logic [W-1:0] out_result_low;
  logic [W-1:0] out_result_high;
  logic         out_carry_out;
  logic         out_zero_out;
  logic         out_overflow_out;
  logic         out_divide_error;

  alu_instr_t  pending_instrs[$];
  alu_result_t due_results[$];

  // Flags as the predictor sees them.
  logic carry_flag, zero_flag, overflow_flag;

  bit beat_taken;
  int burst_left, gap_left;
  int accepted_count, total_instrs, mismatch_count, idle_cycles;

  x86_arith_alu_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_is_word       (in_is_word),
    .in_first_value   (in_first_value),
    .in_second_value  (in_second_value),
    .out_valid        (out_valid),
    .out_result_low   (out_result_low),
    .out_result_high  (out_result_high),
    .out_carry_out    (out_carry_out),
    .out_zero_out     (out_zero_out),
    .out_overflow_out (out_overflow_out),
    .out_divide_error (out_divide_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Executes one instruction against the tracked flags and returns the result.
  function automatic alu_result_t execute_instr(alu_instr_t ins);
    alu_result_t  r;
    logic [W-1:0] mask, sign, a, b, quot;
    logic [W:0]   sum;
    logic [2*W-1:0] prod;
    logic         cin;
    logic [7:0]   divisor;
    r = '{default: '0};
    mask = ins.is_word ? 16'hFFFF : 16'h00FF;
    sign = ins.is_word ? 16'h8000 : 16'h0080;
    a = ins.first_value & mask;
    b = ins.second_value & mask;
    case (ins.mode)
      MODE_ADD, MODE_ADC: begin
        cin = (ins.mode == MODE_ADC) ? carry_flag : 1'b0;
        sum = {1'b0, a} + {1'b0, b} + cin;
        r.result_low = sum[W-1:0] & mask;
        carry_flag = ins.is_word ? sum[W] : sum[8];
        zero_flag = (r.result_low == '0);
        overflow_flag = ((a ^ b) & sign) == '0 && ((a ^ r.result_low) & sign) != '0;
      end
      MODE_SUB, MODE_SBB: begin
        cin = (ins.mode == MODE_SBB) ? carry_flag : 1'b0;
        r.result_low = (a - b - cin) & mask;
        carry_flag = ({1'b0, a} < ({1'b0, b} + cin));
        zero_flag = (r.result_low == '0);
        overflow_flag = ((a ^ b) & sign) != '0 && ((a ^ r.result_low) & sign) != '0;
      end
      MODE_MUL: begin
        prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        r.result_low = prod[W-1:0];
        r.result_high = prod[2*W-1:W];
        carry_flag = ins.is_word ? (prod[2*W-1:W] != '0) : (prod[W-1:8] != '0);
        overflow_flag = carry_flag;
      end
      MODE_DIV: begin
        // Always byte-wide; flags are left alone either way.
        divisor = ins.second_value[7:0];
        quot = (divisor == 8'd0) ? '0 : ins.first_value / {8'd0, divisor};
        if (divisor == 8'd0 || quot > 16'd255) begin
          r.divide_error = 1'b1;
          r.result_low = ins.first_value;
        end else begin
          r.result_low = {8'(ins.first_value % {8'd0, divisor}), quot[7:0]};
        end
      end
      default: ;
    endcase
    r.carry = carry_flag;
    r.zero = zero_flag;
    r.overflow = overflow_flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic [W-1:0] want, logic [W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic queue_instr(mode_t mode, logic is_word, logic [W-1:0] a, logic [W-1:0] b,
                             bit drain = 1'b0);
    alu_instr_t ins;
    ins.mode = mode;
    ins.is_word = is_word;
    ins.first_value = a;
    ins.second_value = b;
    ins.wait_for_drain = drain;
    pending_instrs.push_back(ins);
  endtask

  // Operand values weighted towards the width and sign boundaries.
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      3: return $urandom_range(0, 1) ? 16'h00FF : 16'h0080;
      4: return 16'($urandom_range(0, 255)) | ($urandom_range(0, 1) ? 16'hFF00 : 16'h0000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Builds the instruction list: directed corners first, then random traffic.
  initial begin
    logic [7:0]   d;
    logic [W-1:0] a;
    mode_t        m;
    int           pick;
    // Byte and word carries, zero results and signed overflow.
    queue_instr(MODE_ADD, 1'b0, 16'h12FF, 16'hAB01);
    queue_instr(MODE_ADC, 1'b0, 16'h0000, 16'h0000);
    queue_instr(MODE_ADD, 1'b0, 16'h007F, 16'h0001);
    queue_instr(MODE_ADD, 1'b1, 16'hFFFF, 16'h0001);
    queue_instr(MODE_ADC, 1'b1, 16'h7FFF, 16'h0000);
    queue_instr(MODE_ADD, 1'b1, 16'h8000, 16'h8000);
    queue_instr(MODE_ADC, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_instr(MODE_SUB, 1'b0, 16'h0000, 16'h0001);
    queue_instr(MODE_SBB, 1'b0, 16'h0001, 16'h0000);
    queue_instr(MODE_SUB, 1'b0, 16'hFF80, 16'h0001);
    queue_instr(MODE_SUB, 1'b1, 16'h8000, 16'h0001);
    queue_instr(MODE_SUB, 1'b1, 16'h0000, 16'hFFFF);
    queue_instr(MODE_SBB, 1'b1, 16'hFFFF, 16'hFFFF);
    // Multiplies with and without an upper half.
    queue_instr(MODE_MUL, 1'b0, 16'hABFF, 16'hCDFF);
    queue_instr(MODE_MUL, 1'b0, 16'hFF02, 16'hFF03);
    queue_instr(MODE_MUL, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_instr(MODE_MUL, 1'b1, 16'h0100, 16'h00FF);
    // Divides: zero divisor, quotient overflow and the widest legal quotient.
    queue_instr(MODE_DIV, 1'b0, 16'h1234, 16'hFF00);
    queue_instr(MODE_DIV, 1'b0, 16'hFFFF, 16'h0001);
    queue_instr(MODE_DIV, 1'b1, 16'hFF00, 16'h00FF);
    queue_instr(MODE_DIV, 1'b1, 16'hFEFF, 16'hAAFF);
    queue_instr(MODE_DIV, 1'b0, 16'd1000, 16'h1207);
    queue_instr(MODE_SPARE6, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_instr(MODE_SPARE7, 1'b0, 16'h8000, 16'h0001, 1'b1);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) m = mode_t'($urandom_range(0, 3));
      else if (pick < 82) m = MODE_MUL;
      else if (pick < 96) m = MODE_DIV;
      else m = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
      if (m == MODE_DIV && $urandom_range(0, 3) != 0) begin
        // Mostly divides that fit, so the quotient path is exercised.
        d = 8'($urandom_range(1, 255));
        a = 16'($urandom_range(0, d * 256 - 1));
        queue_instr(m, 1'($urandom), a, {8'($urandom), d}, $urandom_range(0, 149) == 0);
      end else begin
        queue_instr(m, 1'($urandom), pick_operand(), pick_operand(),
                    $urandom_range(0, 149) == 0);
      end
    end
    total_instrs = pending_instrs.size();
  end

  // Reset and the end-of-run check.
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (accepted_count != total_instrs || due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Driver: presents instruction beats in bursts, holding each until taken.
  initial begin
    start = 1'b0;
    in_mode = '0;
    in_is_word = 1'b0;
    in_first_value = '0;
    in_second_value = '0;
    burst_left = 1;
    gap_left = 0;
  end

  always @(negedge clk) begin
    alu_instr_t ins;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // Beat still waiting for the block.
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_instrs.size() != 0 &&
                 !(pending_instrs[0].wait_for_drain && due_results.size() != 0)) begin
      ins = pending_instrs.pop_front();
      in_mode <= ins.mode;
      in_is_word <= ins.is_word;
      in_first_value <= ins.first_value;
      in_second_value <= ins.second_value;
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(0, 4) == 0 ? 40 : $urandom_range(1, 12);
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks result beats, then predicts newly accepted instructions.
  always @(posedge clk) begin
    alu_result_t due;
    alu_instr_t  ins;
    if (!rst_n) begin
      carry_flag = 1'b0;
      zero_flag = 1'b0;
      overflow_flag = 1'b0;
      beat_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result beat with no instruction outstanding");
          mismatch_count++;
        end else begin
          due = due_results.pop_front();
          check_field("result_low", due.result_low, out_result_low);
          check_field("result_high", due.result_high, out_result_high);
          check_field("carry_out", W'(due.carry), W'(out_carry_out));
          check_field("zero_out", W'(due.zero), W'(out_zero_out));
          check_field("overflow_out", W'(due.overflow), W'(out_overflow_out));
          check_field("divide_error", W'(due.divide_error), W'(out_divide_error));
        end
      end
      beat_taken <= start && !busy;
      if (start && !busy) begin
        ins.mode = in_mode;
        ins.is_word = in_is_word;
        ins.first_value = in_first_value;
        ins.second_value = in_second_value;
        ins.wait_for_drain = 1'b0;
        due_results.push_back(execute_instr(ins));
        accepted_count++;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

### files.f
sv/xaa_pkg.sv
sv/xaa_ctrl.sv
sv/xaa_dp.sv
sv/x86_arith_alu_core.sv
sim/tb.sv
